// ===== rtl/ring_buffer_scroll_addresser_core_macros.svh =====
// Assertion macros shared by the ring buffer scroll addresser RTL.
`ifndef RING_BUFFER_SCROLL_ADDRESSER_CORE_MACROS_SVH
`define RING_BUFFER_SCROLL_ADDRESSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBSA_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RBSA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rbsa_pkg.sv =====
// Types, codes and default sizes for the ring buffer scroll addresser.
package rbsa_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int DEF_ADDR_BITS      = 16;
    localparam int DEF_MAX_HEIGHT     = 1024;
    localparam int DEF_MAX_LINE_BYTES = 128;

    // Fixed field widths.
    localparam int OP_W      = 2;
    localparam int POS_W     = 12;
    localparam int PAT_W     = 16;
    localparam int BYTE_W    = 8;
    localparam int CMD_W     = 2;
    localparam int EDGE_W    = 13;
    localparam int MADDR_W   = 16;
    localparam int PLANE_W   = 32;
    localparam int FBASE_W   = 16;
    localparam int SIZE_W    = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Input operations.
    localparam logic [OP_W-1:0] OP_DRAW   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_BOTTOM = 2'd2;
    localparam logic [OP_W-1:0] OP_TOP    = 2'd3;

    // Result commands.
    localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FONT_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_CODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ENABLE = 3'd4;

    // Configuration reset values.
    localparam logic [FBASE_W-1:0] RST_FONT_BASE    = 16'd0;
    localparam logic [SIZE_W-1:0]  RST_IMAGE_WIDTH  = 11'd8;
    localparam logic [SIZE_W-1:0]  RST_IMAGE_HEIGHT = 11'd1;
    localparam logic [PLANE_W-1:0] RST_COLOR_CODE   = 32'd0;
    localparam logic [PLANE_W-1:0] RST_WRITE_ENABLE = 32'd0;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [EDGE_W-1:0]  x_start;
        logic [EDGE_W-1:0]  y_start;
        logic [EDGE_W-1:0]  x_end;
        logic [EDGE_W-1:0]  y_end;
        logic [MADDR_W-1:0] memory_address;
        logic [BYTE_W-1:0]  write_data;
        logic [PLANE_W-1:0] plane_color;
        logic [PLANE_W-1:0] plane_enable;
        logic               last;
    } result_t;

endpackage

// ===== rtl/ring_buffer_scroll_addresser_core.sv =====
// Ring buffer scroll addresser: line-ring pointer update and command generation.
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+----------------------------------
//  s_       | in        | s_valid / s_ready          | operation, position, pattern, byte
//  m_       | out       | m_valid / m_ready          | one or two commands per item, last
//  cfg_     | in        | cfg_valid / cfg_ready      | register index and write data
//
// An item is turned into its first result in the cycle it is accepted; the result
// register shows it from the next cycle. A draw with a non-empty base block gives a
// second result, queued behind the first, and s_ready is low while that result waits.
// Otherwise one item per cycle is taken while m_ready stays high; a stall on m_
// holds s_ready low once the result register is full. After reset, and after a
// write to font_base, image_width or image_height, a set-up pass rebuilds the
// ring pointers, with s_ready low. aresetn is synchronous and active low.
`include "ring_buffer_scroll_addresser_core_macros.svh"

module ring_buffer_scroll_addresser_core #(
    parameter int ADDR_BITS      = rbsa_pkg::DEF_ADDR_BITS,
    parameter int MAX_HEIGHT     = rbsa_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_LINE_BYTES = rbsa_pkg::DEF_MAX_LINE_BYTES
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [rbsa_pkg::OP_W-1:0]       s_operation,
    input  logic [rbsa_pkg::POS_W-1:0]      s_pos_x,
    input  logic [rbsa_pkg::POS_W-1:0]      s_pos_y,
    input  logic [rbsa_pkg::PAT_W-1:0]      s_pattern_address,
    input  logic [rbsa_pkg::BYTE_W-1:0]     s_line_byte,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rbsa_pkg::CMD_W-1:0]      m_command,
    output logic [rbsa_pkg::EDGE_W-1:0]     m_x_start,
    output logic [rbsa_pkg::EDGE_W-1:0]     m_y_start,
    output logic [rbsa_pkg::EDGE_W-1:0]     m_x_end,
    output logic [rbsa_pkg::EDGE_W-1:0]     m_y_end,
    output logic [rbsa_pkg::MADDR_W-1:0]    m_memory_address,
    output logic [rbsa_pkg::BYTE_W-1:0]     m_write_data,
    output logic [rbsa_pkg::PLANE_W-1:0]    m_plane_color,
    output logic [rbsa_pkg::PLANE_W-1:0]    m_plane_enable,
    output logic                            m_last,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rbsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbsa_pkg::CFG_DAT_W-1:0]  cfg_data
);
    import rbsa_pkg::*;

    // Widths that follow from the size limits.
    localparam int H_BITS  = $clog2(MAX_HEIGHT + 1);
    localparam int LB_BITS = $clog2(MAX_LINE_BYTES + 1);
    localparam int EW_BITS = $clog2(MAX_LINE_BYTES * 8 + 1);
    localparam int SPAN_W  = H_BITS + LB_BITS;
    // Comparison widths for clamping the 11-bit size registers.
    localparam int WCMP_W  = 12;
    localparam int HCMP_W  = 13;

    // Configuration registers.
    logic [FBASE_W-1:0] font_base_reg;
    logic [SIZE_W-1:0]  image_width_reg;
    logic [SIZE_W-1:0]  image_height_reg;
    logic [PLANE_W-1:0] color_code_reg;
    logic [PLANE_W-1:0] write_enable_reg;

    // Ring state.
    logic [ADDR_BITS-1:0] ring_start_reg, ring_start_next;
    logic [ADDR_BITS-1:0] ring_top_reg, ring_top_next;
    logic [LB_BITS-1:0]   line_bytes_reg, line_bytes_next;
    logic [H_BITS-1:0]    start_lines_reg, start_lines_next;
    logic [H_BITS-1:0]    base_lines_reg, base_lines_next;
    logic [LB_BITS-1:0]   byte_index_reg, byte_index_next;
    logic                 init_pending_reg, init_pending_next;

    // Result registers: the shown result and a second one queued behind it.
    result_t out_reg, out_next;
    result_t second_reg, second_next;
    logic    out_valid_reg, out_valid_next;
    logic    second_valid_reg, second_valid_next;

    // Handshakes.
    logic accept_in;
    logic take_out;
    logic cfg_write;
    logic geom_write;

    // Effective sizes and set-up values.
    logic [EW_BITS-1:0]   eff_width;
    logic [H_BITS-1:0]    eff_height;
    logic [EW_BITS:0]     width_round;
    logic [LB_BITS-1:0]   init_line_bytes;
    logic [SPAN_W-1:0]    init_span;
    logic [ADDR_BITS-1:0] font_addr;

    // Per-item working values.
    logic                 line_op;
    logic                 first_byte;
    logic [ADDR_BITS-1:0] line_step;
    logic [ADDR_BITS-1:0] step_start;
    logic [H_BITS-1:0]    step_start_lines;
    logic [H_BITS-1:0]    step_base_lines;
    logic [ADDR_BITS-1:0] write_addr;
    logic [LB_BITS-1:0]   byte_index_inc;
    logic [EDGE_W-1:0]    edge_x_end;
    logic [EDGE_W-1:0]    edge_y_top;
    logic [EDGE_W-1:0]    edge_y_split;
    result_t              res_first;
    result_t              res_second;
    logic                 res_two;

    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign geom_write = cfg_write && (cfg_index == REG_FONT_BASE ||
                                      cfg_index == REG_IMAGE_WIDTH ||
                                      cfg_index == REG_IMAGE_HEIGHT);

    // The result register frees up when it is empty, or when its item leaves this
    // cycle and no second result is queued behind it.
    assign s_ready   = !init_pending_reg &&
                       (!out_valid_reg || (m_ready && !second_valid_reg));
    assign accept_in = s_valid && s_ready;
    assign take_out  = out_valid_reg && m_ready;

    // Width and height are clamped to at least one and to the size limits.
    always_comb begin
        if (image_width_reg == '0) begin
            eff_width = EW_BITS'(1);
        end else if (WCMP_W'(image_width_reg) > WCMP_W'(MAX_LINE_BYTES * 8)) begin
            eff_width = EW_BITS'(MAX_LINE_BYTES * 8);
        end else begin
            eff_width = EW_BITS'(image_width_reg);
        end

        if (image_height_reg == '0) begin
            eff_height = H_BITS'(1);
        end else if (HCMP_W'(image_height_reg) > HCMP_W'(MAX_HEIGHT)) begin
            eff_height = H_BITS'(MAX_HEIGHT);
        end else begin
            eff_height = H_BITS'(image_height_reg);
        end
    end

    assign width_round     = {1'b0, eff_width} + (EW_BITS + 1)'(7);
    assign init_line_bytes = LB_BITS'(width_round >> 3);
    assign init_span       = {{LB_BITS{1'b0}}, eff_height} *
                             {{H_BITS{1'b0}}, init_line_bytes};
    assign font_addr       = ADDR_BITS'(font_base_reg);

    // Rectangle edges wrap at the edge width.
    assign edge_x_end   = EDGE_W'(s_pos_x) + EDGE_W'(eff_width) - EDGE_W'(1);
    assign edge_y_top   = EDGE_W'(s_pos_y) + EDGE_W'(eff_height) - EDGE_W'(1);
    assign edge_y_split = EDGE_W'(s_pos_y) + EDGE_W'(start_lines_reg);

    // Pointer movement on the first byte of a new line.
    assign line_op    = (s_operation == OP_BOTTOM) || (s_operation == OP_TOP);
    assign first_byte = (byte_index_reg == '0);
    assign line_step  = ADDR_BITS'(line_bytes_reg);

    always_comb begin
        step_start       = ring_start_reg;
        step_start_lines = start_lines_reg;
        step_base_lines  = base_lines_reg;
        if (first_byte) begin
            if (s_operation == OP_BOTTOM) begin
                // A line added below: the start block grows downwards through
                // memory, wrapping from the region base to its top.
                if (base_lines_reg == '0) begin
                    step_start_lines = H_BITS'(1);
                    step_base_lines  = eff_height - H_BITS'(1);
                    step_start       = ring_top_reg - line_step;
                end else begin
                    step_start_lines = start_lines_reg + H_BITS'(1);
                    step_base_lines  = base_lines_reg - H_BITS'(1);
                    step_start       = ring_start_reg - line_step;
                end
            end else begin
                // A line added on top: the start block shrinks upwards until it
                // wraps back to the region base as one whole block.
                if (start_lines_reg <= H_BITS'(1)) begin
                    step_start_lines = eff_height;
                    step_base_lines  = '0;
                    step_start       = font_addr;
                end else begin
                    step_start_lines = start_lines_reg - H_BITS'(1);
                    step_base_lines  = base_lines_reg + H_BITS'(1);
                    step_start       = ring_start_reg + line_step;
                end
            end
        end
    end

    assign write_addr     = step_start + ADDR_BITS'(byte_index_reg);
    assign byte_index_inc = byte_index_reg + LB_BITS'(1);

    // Results of the item at the input.
    always_comb begin
        res_first  = '0;
        res_second = '0;
        res_two    = 1'b0;
        case (s_operation)
            OP_DRAW: begin
                res_two                     = (base_lines_reg != '0);
                res_first.command           = CMD_DRAW;
                res_first.x_start           = EDGE_W'(s_pos_x);
                res_first.y_start           = EDGE_W'(s_pos_y);
                res_first.x_end             = edge_x_end;
                res_first.y_end             = edge_y_split - EDGE_W'(1);
                res_first.memory_address    = MADDR_W'(ring_start_reg);
                res_first.plane_color       = color_code_reg;
                res_first.plane_enable      = write_enable_reg;
                res_first.last              = !res_two;
                res_second.command          = CMD_DRAW;
                res_second.x_start          = EDGE_W'(s_pos_x);
                res_second.y_start          = edge_y_split;
                res_second.x_end            = edge_x_end;
                res_second.y_end            = edge_y_top;
                res_second.memory_address   = MADDR_W'(font_addr);
                res_second.plane_color      = color_code_reg;
                res_second.plane_enable     = write_enable_reg;
                res_second.last             = 1'b1;
            end
            OP_CLEAR: begin
                res_first.command           = CMD_CLEAR;
                res_first.x_start           = EDGE_W'(s_pos_x);
                res_first.y_start           = EDGE_W'(s_pos_y);
                res_first.x_end             = edge_x_end;
                res_first.y_end             = edge_y_top;
                res_first.memory_address    = s_pattern_address;
                res_first.plane_color       = ~color_code_reg;
                res_first.plane_enable      = write_enable_reg;
                res_first.last              = 1'b1;
            end
            default: begin
                res_first.command           = CMD_WRITE;
                res_first.memory_address    = MADDR_W'(write_addr);
                res_first.write_data        = s_line_byte;
                res_first.last              = 1'b1;
            end
        endcase
    end

    // Next state of the ring.
    always_comb begin
        ring_start_next   = ring_start_reg;
        ring_top_next     = ring_top_reg;
        line_bytes_next   = line_bytes_reg;
        start_lines_next  = start_lines_reg;
        base_lines_next   = base_lines_reg;
        byte_index_next   = byte_index_reg;
        init_pending_next = geom_write;

        if (init_pending_reg) begin
            ring_start_next  = font_addr;
            ring_top_next    = font_addr + ADDR_BITS'(init_span);
            line_bytes_next  = init_line_bytes;
            start_lines_next = eff_height;
            base_lines_next  = '0;
            byte_index_next  = '0;
        end else if (accept_in && line_op) begin
            ring_start_next  = step_start;
            start_lines_next = step_start_lines;
            base_lines_next  = step_base_lines;
            byte_index_next  = (byte_index_inc >= line_bytes_reg) ? '0 : byte_index_inc;
        end
    end

    // Next state of the result registers.
    always_comb begin
        out_next          = out_reg;
        second_next       = second_reg;
        out_valid_next    = out_valid_reg;
        second_valid_next = second_valid_reg;
        if (accept_in) begin
            out_next          = res_first;
            second_next       = res_second;
            out_valid_next    = 1'b1;
            second_valid_next = res_two;
        end else if (take_out) begin
            if (second_valid_reg) begin
                out_next          = second_reg;
                second_valid_next = 1'b0;
            end else begin
                out_valid_next    = 1'b0;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            font_base_reg    <= RST_FONT_BASE;
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            color_code_reg   <= RST_COLOR_CODE;
            write_enable_reg <= RST_WRITE_ENABLE;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_FONT_BASE:    font_base_reg    <= FBASE_W'(cfg_data);
                REG_IMAGE_WIDTH:  image_width_reg  <= SIZE_W'(cfg_data);
                REG_IMAGE_HEIGHT: image_height_reg <= SIZE_W'(cfg_data);
                REG_COLOR_CODE:   color_code_reg   <= cfg_data;
                REG_WRITE_ENABLE: write_enable_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Ring state and control. Reset leaves a set-up pass pending, which loads the
    // ring from the reset configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_start_reg   <= '0;
            ring_top_reg     <= '0;
            line_bytes_reg   <= '0;
            start_lines_reg  <= '0;
            base_lines_reg   <= '0;
            byte_index_reg   <= '0;
            init_pending_reg <= 1'b1;
            out_valid_reg    <= 1'b0;
            second_valid_reg <= 1'b0;
        end else begin
            ring_start_reg   <= ring_start_next;
            ring_top_reg     <= ring_top_next;
            line_bytes_reg   <= line_bytes_next;
            start_lines_reg  <= start_lines_next;
            base_lines_reg   <= base_lines_next;
            byte_index_reg   <= byte_index_next;
            init_pending_reg <= init_pending_next;
            out_valid_reg    <= out_valid_next;
            second_valid_reg <= second_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        out_reg    <= out_next;
        second_reg <= second_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_command        = out_reg.command;
    assign m_x_start        = out_reg.x_start;
    assign m_y_start        = out_reg.y_start;
    assign m_x_end          = out_reg.x_end;
    assign m_y_end          = out_reg.y_end;
    assign m_memory_address = out_reg.memory_address;
    assign m_write_data     = out_reg.write_data;
    assign m_plane_color    = out_reg.plane_color;
    assign m_plane_enable   = out_reg.plane_enable;
    assign m_last           = out_reg.last;

    // The two blocks always cover the whole image height.
    `RBSA_ASSERT_IMP(a_blocks_cover_height, aclk, aresetn, !init_pending_reg,
        (H_BITS + 1)'(start_lines_reg) + (H_BITS + 1)'(base_lines_reg) ==
        (H_BITS + 1)'(eff_height), "start and base blocks do not cover the image")

    // The byte position stays inside the current line.
    `RBSA_ASSERT_IMP(a_byte_index_in_line, aclk, aresetn, !init_pending_reg,
        byte_index_reg < line_bytes_reg, "byte index outside the line")

    // A queued second result only ever sits behind a shown first result.
    `RBSA_ASSERT_IMP(a_second_behind_first, aclk, aresetn, second_valid_reg,
        out_valid_reg && !out_reg.last, "second result queued without its first")

    // A shown result that is not taken stays in place.
    `RBSA_ASSERT_NEXT(a_result_held, aclk, aresetn, out_valid_reg && !m_ready,
        out_valid_reg && $stable(out_reg), "result changed while stalled")

endmodule

// ===== bench/tb_ring_buffer_scroll_addresser_core.sv =====
// Self-checking testbench for the ring buffer scroll addresser core.
module tb_ring_buffer_scroll_addresser_core;
    import rbsa_pkg::*;

    // Timing of the run. The limit sits far above the slowest legal run: about 1850
    // items, each with at most two results that may wait out a heavy receiver stall.
    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 16;
    localparam int LIMIT_CYCLES  = 500000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 150;
    localparam int MAX_WIDTH_PX  = DEF_MAX_LINE_BYTES * 8;

    // Register indexes past the last real register; the block must ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_WRITE_ENABLE + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;

    typedef enum logic {ENTRY_ITEM, ENTRY_REG} entry_kind_t;
    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_PATTERN, RX_HEAVY} rx_mode_t;

    // One entry of the stimulus list: either an item for the s_ channel or a
    // register write for the cfg_ channel.
    typedef struct packed {
        entry_kind_t          kind;
        logic [OP_W-1:0]      operation;
        logic [POS_W-1:0]     pos_x;
        logic [POS_W-1:0]     pos_y;
        logic [PAT_W-1:0]     pattern_address;
        logic [BYTE_W-1:0]    line_byte;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CFG_DAT_W-1:0] reg_value;
    } pending_t;

    // Every input of the block starts at a known value.
    logic                  aclk              = 1'b0;
    logic                  aresetn           = 1'b0;
    logic                  s_valid           = 1'b0;
    logic                  s_ready;
    logic [OP_W-1:0]       s_operation       = OP_DRAW;
    logic [POS_W-1:0]      s_pos_x           = '0;
    logic [POS_W-1:0]      s_pos_y           = '0;
    logic [PAT_W-1:0]      s_pattern_address = '0;
    logic [BYTE_W-1:0]     s_line_byte       = '0;
    logic                  m_valid;
    logic                  m_ready           = 1'b0;
    logic [CMD_W-1:0]      m_command;
    logic [EDGE_W-1:0]     m_x_start;
    logic [EDGE_W-1:0]     m_y_start;
    logic [EDGE_W-1:0]     m_x_end;
    logic [EDGE_W-1:0]     m_y_end;
    logic [MADDR_W-1:0]    m_memory_address;
    logic [BYTE_W-1:0]     m_write_data;
    logic [PLANE_W-1:0]    m_plane_color;
    logic [PLANE_W-1:0]    m_plane_enable;
    logic                  m_last;
    logic                  cfg_valid         = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index         = '0;
    logic [CFG_DAT_W-1:0]  cfg_data          = '0;

    // Stimulus list, the item now on the s_ channel, and the commands still owed.
    pending_t    pending_items[$];
    pending_t    in_flight;
    result_t     expected_cmds[$];

    int          error_count  = 0;
    int          cycle_count  = 0;
    int          quiet_cycles = 0;
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned stall_tick;
    rx_mode_t    stall_mode;
    logic [7:0]  stall_mask;

    // Mirror of the configuration registers.
    logic [FBASE_W-1:0] base_addr;
    logic [SIZE_W-1:0]  width_px;
    logic [SIZE_W-1:0]  height_lines;
    logic [PLANE_W-1:0] draw_color;
    logic [PLANE_W-1:0] plane_mask;

    // Mirror of the ring: head_addr is where the lowest drawn line lives, region_end
    // the first address past the image region, head_lines and wrap_lines the sizes of
    // the two blocks that are drawn, and fill_pos the byte position within a new line.
    logic [MADDR_W-1:0] head_addr;
    logic [MADDR_W-1:0] region_end;
    int unsigned        bytes_per_line;
    int unsigned        head_lines;
    int unsigned        wrap_lines;
    int unsigned        fill_pos;

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    ring_buffer_scroll_addresser_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_pos_x           (s_pos_x),
        .s_pos_y           (s_pos_y),
        .s_pattern_address (s_pattern_address),
        .s_line_byte       (s_line_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_command         (m_command),
        .m_x_start         (m_x_start),
        .m_y_start         (m_y_start),
        .m_x_end           (m_x_end),
        .m_y_end           (m_y_end),
        .m_memory_address  (m_memory_address),
        .m_write_data      (m_write_data),
        .m_plane_color     (m_plane_color),
        .m_plane_enable    (m_plane_enable),
        .m_last            (m_last),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // The block works with the width and height held inside their legal ranges;
    // a zero size counts as one.
    function automatic int unsigned clamp_width(logic [SIZE_W-1:0] w);
        if (w == 0) return 1;
        if (w > MAX_WIDTH_PX) return MAX_WIDTH_PX;
        return w;
    endfunction

    function automatic int unsigned clamp_height(logic [SIZE_W-1:0] h);
        if (h == 0) return 1;
        if (h > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
        return h;
    endfunction

    function automatic int unsigned bytes_for_width(logic [SIZE_W-1:0] w);
        return (clamp_width(w) + 7) >> 3;
    endfunction

    // A change of base, width or height puts the whole image back in the head block.
    function automatic void rebuild_ring();
        bytes_per_line = bytes_for_width(width_px);
        head_addr      = base_addr;
        region_end     = MADDR_W'(base_addr + clamp_height(height_lines) * bytes_per_line);
        head_lines     = clamp_height(height_lines);
        wrap_lines     = 0;
        fill_pos       = 0;
    endfunction

    function automatic void apply_register_write(logic [CFG_IDX_W-1:0] idx,
                                                 logic [CFG_DAT_W-1:0] value);
        case (idx)
            REG_FONT_BASE: begin
                base_addr = value[FBASE_W-1:0];
                rebuild_ring();
            end
            REG_IMAGE_WIDTH: begin
                width_px = value[SIZE_W-1:0];
                rebuild_ring();
            end
            REG_IMAGE_HEIGHT: begin
                height_lines = value[SIZE_W-1:0];
                rebuild_ring();
            end
            REG_COLOR_CODE:   draw_color = value[PLANE_W-1:0];
            REG_WRITE_ENABLE: plane_mask = value[PLANE_W-1:0];
            default: ;
        endcase
    endfunction

    // Works out the commands that one accepted item must produce and queues them.
    function automatic void predict_commands(pending_t it);
        result_t     cmd;
        int unsigned w;
        int unsigned h;
        w   = clamp_width(width_px);
        h   = clamp_height(height_lines);
        cmd = '0;
        case (it.operation)
            OP_DRAW: begin
                // The head block is drawn at the bottom; the wrapped block, if any,
                // sits above it and is read from the start of the region.
                cmd.command        = CMD_DRAW;
                cmd.x_start        = EDGE_W'(it.pos_x);
                cmd.y_start        = EDGE_W'(it.pos_y);
                cmd.x_end          = EDGE_W'(it.pos_x + w - 1);
                cmd.y_end          = EDGE_W'(it.pos_y + head_lines - 1);
                cmd.memory_address = head_addr;
                cmd.plane_color    = draw_color;
                cmd.plane_enable   = plane_mask;
                cmd.last           = (wrap_lines == 0);
                expected_cmds.push_back(cmd);
                if (wrap_lines != 0) begin
                    cmd.y_start        = EDGE_W'(it.pos_y + head_lines);
                    cmd.y_end          = EDGE_W'(it.pos_y + h - 1);
                    cmd.memory_address = base_addr;
                    cmd.last           = 1'b1;
                    expected_cmds.push_back(cmd);
                end
            end
            OP_CLEAR: begin
                cmd.command        = CMD_CLEAR;
                cmd.x_start        = EDGE_W'(it.pos_x);
                cmd.y_start        = EDGE_W'(it.pos_y);
                cmd.x_end          = EDGE_W'(it.pos_x + w - 1);
                cmd.y_end          = EDGE_W'(it.pos_y + h - 1);
                cmd.memory_address = it.pattern_address;
                cmd.plane_color    = ~draw_color;
                cmd.plane_enable   = plane_mask;
                cmd.last           = 1'b1;
                expected_cmds.push_back(cmd);
            end
            default: begin
                // Only the first byte of a line moves the ring; later bytes keep writing
                // the same line whatever their operation.
                if (fill_pos == 0) begin
                    if (it.operation == OP_BOTTOM) begin
                        if (wrap_lines == 0) begin
                            head_lines = 1;
                            wrap_lines = h - 1;
                            head_addr  = MADDR_W'(region_end - bytes_per_line);
                        end else begin
                            head_lines = head_lines + 1;
                            wrap_lines = wrap_lines - 1;
                            head_addr  = MADDR_W'(head_addr - bytes_per_line);
                        end
                    end else if (head_lines <= 1) begin
                        head_lines = h;
                        wrap_lines = 0;
                        head_addr  = base_addr;
                    end else begin
                        head_lines = head_lines - 1;
                        wrap_lines = wrap_lines + 1;
                        head_addr  = MADDR_W'(head_addr + bytes_per_line);
                    end
                end
                cmd.command        = CMD_WRITE;
                cmd.memory_address = MADDR_W'(head_addr + fill_pos);
                cmd.write_data     = it.line_byte;
                cmd.last           = 1'b1;
                expected_cmds.push_back(cmd);
                fill_pos = fill_pos + 1;
                if (fill_pos >= bytes_per_line) fill_pos = 0;
            end
        endcase
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    function automatic void queue_item(logic [OP_W-1:0] op, logic [POS_W-1:0] x,
                                       logic [POS_W-1:0] y, logic [PAT_W-1:0] pat,
                                       logic [BYTE_W-1:0] data);
        pending_t e;
        e                 = '0;
        e.kind            = ENTRY_ITEM;
        e.operation       = op;
        e.pos_x           = x;
        e.pos_y           = y;
        e.pattern_address = pat;
        e.line_byte       = data;
        pending_items.push_back(e);
    endfunction

    function automatic void queue_random_item(logic [OP_W-1:0] op);
        queue_item(op, POS_W'($urandom), POS_W'($urandom), PAT_W'($urandom),
                   BYTE_W'($urandom));
    endfunction

    function automatic void queue_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DAT_W-1:0] value);
        pending_t e;
        e           = '0;
        e.kind      = ENTRY_REG;
        e.reg_index = idx;
        e.reg_value = value;
        pending_items.push_back(e);
    endfunction

    function automatic void queue_settings(logic [FBASE_W-1:0] base, logic [SIZE_W-1:0] width,
                                           logic [SIZE_W-1:0] height, logic [PLANE_W-1:0] color,
                                           logic [PLANE_W-1:0] mask);
        queue_register(REG_FONT_BASE, CFG_DAT_W'(base));
        queue_register(REG_IMAGE_WIDTH, CFG_DAT_W'(width));
        queue_register(REG_IMAGE_HEIGHT, CFG_DAT_W'(height));
        queue_register(REG_COLOR_CODE, color);
        queue_register(REG_WRITE_ENABLE, mask);
    endfunction

    // Mostly whole lines of bytes with random content, scrolling in runs of one
    // direction, with draws and clears in between and now and then inside a line.
    // About one line in ten is cut short, which shifts the line boundaries.
    function automatic void queue_scroll_traffic(int unsigned lb, int unsigned count);
        int unsigned     queued;
        int unsigned     line_pos;
        int unsigned     run;
        int unsigned     roll;
        logic [OP_W-1:0] dir;
        logic [OP_W-1:0] other;
        queued   = 0;
        line_pos = 0;
        dir      = OP_BOTTOM;
        while (queued < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                queue_random_item(OP_DRAW);
                queued++;
            end else if (roll < 18) begin
                queue_random_item(OP_CLEAR);
                queued++;
            end else begin
                if ($urandom_range(0, 3) == 0) dir = (dir == OP_BOTTOM) ? OP_TOP : OP_BOTTOM;
                other = (dir == OP_BOTTOM) ? OP_TOP : OP_BOTTOM;
                run   = lb - line_pos;
                if ($urandom_range(0, 9) == 0) run = $urandom_range(1, run);
                repeat (run) begin
                    queue_random_item(($urandom_range(0, 7) == 0) ? other : dir);
                    queued++;
                    if ($urandom_range(0, 15) == 0) begin
                        queue_random_item(($urandom_range(0, 1) != 0) ? OP_DRAW : OP_CLEAR);
                        queued++;
                    end
                end
                line_pos = (line_pos + run) % lb;
            end
        end
    endfunction

    // Sender. Items go out in bursts of random length with random gaps between them,
    // and now and then a long burst with no gap at all. A register write waits until
    // every command owed has come back and the block has gone quiet.
    always @(posedge aclk) begin : item_driver
        pending_t next_entry;
        if (!aresetn) begin
            s_valid      <= 1'b0;
            cfg_valid    <= 1'b0;
            burst_left   = 0;
            gap_left     = 0;
            base_addr    = RST_FONT_BASE;
            width_px     = RST_IMAGE_WIDTH;
            height_lines = RST_IMAGE_HEIGHT;
            draw_color   = RST_COLOR_CODE;
            plane_mask   = RST_WRITE_ENABLE;
            rebuild_ring();
        end else begin
            if (s_valid && s_ready) predict_commands(in_flight);
            if (cfg_valid && cfg_ready) apply_register_write(cfg_index, cfg_data);

            if ((s_valid && !s_ready) || (cfg_valid && !cfg_ready)) begin
                // Still waiting for the handshake: hold valid and payload.
            end else if (pending_items.size() == 0) begin
                s_valid   <= 1'b0;
                cfg_valid <= 1'b0;
            end else if (pending_items[0].kind == ENTRY_REG) begin
                s_valid <= 1'b0;
                if (quiet_cycles >= SETTLE_CYCLES) begin
                    next_entry = pending_items.pop_front();
                    cfg_index <= next_entry.reg_index;
                    cfg_data  <= next_entry.reg_value;
                    cfg_valid <= 1'b1;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end else begin
                cfg_valid <= 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    next_entry = pending_items.pop_front();
                    in_flight  = next_entry;
                    s_operation       <= next_entry.operation;
                    s_pos_x           <= next_entry.pos_x;
                    s_pos_y           <= next_entry.pos_y;
                    s_pattern_address <= next_entry.pattern_address;
                    s_line_byte       <= next_entry.line_byte;
                    s_valid           <= 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        if ($urandom_range(0, 7) == 0) begin
                            burst_left = $urandom_range(40, 160);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 12);
                            gap_left   = $urandom_range(1, 6);
                        end
                    end
                end
            end
        end
    end

    // Receiver and checker. Each accepted command is compared with the oldest one
    // owed. The ready pattern switches at random between always ready, light
    // random stalls, a repeating mask and heavy random stalls.
    always @(posedge aclk) begin : result_monitor
        result_t got;
        result_t want;
        logic    next_ready;
        if (!aresetn) begin
            m_ready      <= 1'b0;
            quiet_cycles <= 0;
            stall_tick   = 0;
            stall_mode   = RX_OPEN;
            stall_mask   = 8'hFF;
        end else begin
            if (m_valid && m_ready) begin
                got.command        = m_command;
                got.x_start        = m_x_start;
                got.y_start        = m_y_start;
                got.x_end          = m_x_end;
                got.y_end          = m_y_end;
                got.memory_address = m_memory_address;
                got.write_data     = m_write_data;
                got.plane_color    = m_plane_color;
                got.plane_enable   = m_plane_enable;
                got.last           = m_last;
                if (expected_cmds.size() == 0) begin
                    $display("%0t: command with none expected: expected nothing, actual %h",
                             $time, got);
                    error_count++;
                end else begin
                    want = expected_cmds.pop_front();
                    compare_field("command", want.command, got.command);
                    compare_field("x_start", want.x_start, got.x_start);
                    compare_field("y_start", want.y_start, got.y_start);
                    compare_field("x_end", want.x_end, got.x_end);
                    compare_field("y_end", want.y_end, got.y_end);
                    compare_field("memory_address", want.memory_address, got.memory_address);
                    compare_field("write_data", want.write_data, got.write_data);
                    compare_field("plane_color", want.plane_color, got.plane_color);
                    compare_field("plane_enable", want.plane_enable, got.plane_enable);
                    compare_field("last", want.last, got.last);
                end
            end

            // The sender only pushes expectations at edges where s_valid was high, so
            // this count does not depend on the order of the two blocks.
            if (s_valid || expected_cmds.size() != 0) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;

            stall_tick++;
            if (stall_tick % 200 == 0) begin
                stall_mode = rx_mode_t'($urandom_range(0, 3));
                stall_mask = 8'($urandom) | 8'h01;
            end
            case (stall_mode)
                RX_OPEN:    next_ready = 1'b1;
                RX_LIGHT:   next_ready = ($urandom_range(0, 3) != 0);
                RX_PATTERN: next_ready = stall_mask[stall_tick % 8];
                default:    next_ready = ($urandom_range(0, 3) == 0);
            endcase
            m_ready <= next_ready;
        end
    end

    // Builds the whole stimulus list, releases reset and waits for the end of the run.
    initial begin : run_control
        logic [SIZE_W-1:0]  width_pick;
        logic [SIZE_W-1:0]  height_pick;
        logic [FBASE_W-1:0] base_pick;
        int unsigned        roll;
        logic               timed_out;
        timed_out = 1'b0;

        // Reset settings: eight pixels wide, one line high. Draws and clears at both
        // corners of the screen and the extremes of the stipple address, with one byte
        // scrolled in from each side between them.
        queue_item(OP_DRAW, '0, '0, '0, '0);
        queue_item(OP_CLEAR, '1, '1, '1, '0);
        queue_item(OP_BOTTOM, 12'hA5A, 12'h5A5, 16'h1234, 8'h00);
        queue_item(OP_TOP, '0, '0, '0, 8'hFF);
        queue_item(OP_DRAW, '1, '1, '1, '1);
        queue_item(OP_CLEAR, '0, '0, '0, 8'h5A);

        // Sizes above their limits, a region that wraps past the top of the address
        // space, and writes to unused register indexes that must change nothing.
        // The line is 128 bytes, so draws, clears and a top byte fall mid-line.
        queue_register(REG_FIRST_UNUSED, '1);
        queue_register(REG_LAST_UNUSED, '0);
        queue_settings(16'hFFF0, '1, '1, '1, 32'hA5A5_5A5A);
        queue_item(OP_DRAW, '1, '1, '0, '0);
        queue_item(OP_BOTTOM, '0, '0, '0, 8'hAA);
        queue_item(OP_DRAW, '0, '0, '1, '1);
        queue_item(OP_TOP, '1, '0, '1, 8'h55);
        queue_item(OP_CLEAR, '1, '0, 16'h8000, '0);
        queue_item(OP_BOTTOM, '0, '1, '0, 8'h01);

        // Zero sizes, which count as a single pixel and a single line.
        queue_settings('0, '0, '0, '0, '1);
        queue_item(OP_TOP, '0, '0, '0, 8'h80);
        queue_item(OP_TOP, '0, '0, '0, 8'h01);
        queue_item(OP_BOTTOM, '0, '0, '0, 8'hFE);
        queue_item(OP_DRAW, 12'd123, 12'd456, '0, '0);

        // Three lines of three bytes just below the top of the address space, so the region
        // crosses the address wrap: one bottom line wraps the ring past the address wrap.
        queue_settings(16'hFFFE, 11'd20, 11'd3, 32'h1234_5678, 32'h0F0F_0F0F);
        queue_item(OP_BOTTOM, '0, '0, '0, 8'h11);
        queue_item(OP_BOTTOM, '0, '0, '0, 8'h22);
        queue_item(OP_TOP, '0, '0, '0, 8'h33);
        queue_item(OP_DRAW, 12'd7, 12'd9, '0, '0);

        // Random phases. Most use small images so that the ring wraps often; a few
        // use a zero height, the largest sizes or sizes beyond the limits.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) width_pick = '1;
            else if (roll == 1) width_pick = SIZE_W'($urandom_range(1000, 1100));
            else width_pick = SIZE_W'($urandom_range(1, 48));
            roll = $urandom_range(0, 9);
            if (roll == 0) height_pick = '0;
            else if (roll == 1) height_pick = SIZE_W'($urandom_range(1000, 2047));
            else height_pick = SIZE_W'($urandom_range(1, 9));
            if ($urandom_range(0, 3) == 0) base_pick = FBASE_W'(16'hFFFF - $urandom_range(0, 300));
            else base_pick = FBASE_W'($urandom);
            queue_settings(base_pick, width_pick, height_pick, $urandom, $urandom);
            if ($urandom_range(0, 3) == 0)
                queue_register(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                               $urandom);
            queue_scroll_traffic(bytes_for_width(width_pick), PHASE_ITEMS);
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        fork
            begin
                while (pending_items.size() != 0 || s_valid || cfg_valid ||
                       expected_cmds.size() != 0)
                    @(posedge aclk);
                repeat (TAIL_CYCLES) @(posedge aclk);
            end
            begin
                wait (cycle_count >= LIMIT_CYCLES);
                timed_out = 1'b1;
            end
        join_any

        if (!timed_out && error_count == 0 && expected_cmds.size() == 0) begin
            $display("tb_ring_buffer_scroll_addresser_core: clean");
        end else begin
            $display("tb_ring_buffer_scroll_addresser_core: errors");
        end
        $finish;
    end

endmodule
